### rtl/keyed_saturating_count_table_assert.svh
// assertion macros for the keyed saturating count table rtl
`ifndef KEYED_SATURATING_COUNT_TABLE_ASSERT_SVH
`define KEYED_SATURATING_COUNT_TABLE_ASSERT_SVH

`ifndef SYNTH

// condition that holds at every clock edge out of reset
`define KSCT_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ksct assertion failed: always");

// consequent holds in the cycle after the antecedent
`define KSCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ksct assertion failed: next cycle");

// consequent holds in the same cycle as the antecedent
`define KSCT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ksct assertion failed: same cycle");

`else

`define KSCT_ASSERT_ALWAYS(label, cond)
`define KSCT_ASSERT_NEXT(label, ante, cons)
`define KSCT_ASSERT_SAME(label, ante, cons)

`endif

`endif

### rtl/ksct_pkg.sv
// types and constants of the keyed saturating count table
package ksct_pkg;

  localparam int KEY_W  = 8;
  localparam int CNT_W  = 8;
  localparam int USED_W = 4;

  localparam logic [CNT_W-1:0]  COUNT_MAX = 8'd255;
  localparam logic [USED_W-1:0] USED_MAX  = 4'd15;

  // code three is unused and behaves as a query
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_t;

  // summary flags of one table lookup
  typedef struct packed {
    logic hit;
    logic free_found;
  } lookup_flags_t;

endpackage

### rtl/ksct_lookup.sv
// parallel key compare, first match, first free slot and slots in use
module ksct_lookup
  import ksct_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  logic [SLOT_COUNT-1:0][KEY_W-1:0] slot_keys,
  input  logic [SLOT_COUNT-1:0][CNT_W-1:0] slot_counts,
  input  logic [KEY_W-1:0]                 key,
  output logic [SLOT_COUNT-1:0]            hit_oh,
  output logic [SLOT_COUNT-1:0]            free_oh,
  output lookup_flags_t                    flags,
  output logic [CNT_W-1:0]                 hit_count,
  output logic [USED_W-1:0]                used_count
);

  localparam int SUM_W = ($clog2(SLOT_COUNT + 1) > USED_W) ? $clog2(SLOT_COUNT + 1) : USED_W;

  logic [SUM_W-1:0] used_sum;

  always_comb begin
    logic seen_hit;
    logic seen_free;
    seen_hit   = 1'b0;
    seen_free  = 1'b0;
    hit_oh     = '0;
    free_oh    = '0;
    hit_count  = '0;
    used_sum   = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      // key zero never matches
      if (key != '0 && slot_keys[i] == key && !seen_hit) begin
        hit_oh[i] = 1'b1;
        seen_hit  = 1'b1;
      end
      if ((slot_keys[i] == '0 || slot_counts[i] == '0) && !seen_free) begin
        free_oh[i] = 1'b1;
        seen_free  = 1'b1;
      end
      hit_count = hit_count | (slot_counts[i] & {CNT_W{hit_oh[i]}});
      used_sum  = used_sum + SUM_W'(slot_keys[i] != '0 && slot_counts[i] != '0);
    end
    flags.hit        = seen_hit;
    flags.free_found = seen_free;
  end

  assign used_count = (used_sum > SUM_W'(USED_MAX)) ? USED_MAX : used_sum[USED_W-1:0];

endmodule

### rtl/ksct_exec.sv
// add and remove arithmetic and next table contents for one request
module ksct_exec
  import ksct_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  opcode_t                          op,
  input  logic [KEY_W-1:0]                 key,
  input  logic [CNT_W-1:0]                 amount,
  input  logic                             key_known,
  input  logic [SLOT_COUNT-1:0][KEY_W-1:0] slot_keys,
  input  logic [SLOT_COUNT-1:0][CNT_W-1:0] slot_counts,
  input  logic [SLOT_COUNT-1:0]            hit_oh,
  input  logic [SLOT_COUNT-1:0]            free_oh,
  input  lookup_flags_t                    flags,
  input  logic [CNT_W-1:0]                 hit_count,
  output logic [SLOT_COUNT-1:0][KEY_W-1:0] slot_keys_nxt,
  output logic [SLOT_COUNT-1:0][CNT_W-1:0] slot_counts_nxt,
  output logic [CNT_W-1:0]                 added,
  output logic                             removed_ok
);

  logic                  add_go;
  logic [SLOT_COUNT-1:0] add_oh;
  logic [CNT_W-1:0]      add_base;
  logic [CNT_W-1:0]      add_room;
  logic [CNT_W-1:0]      add_amt;
  logic                  rem_go;
  logic [CNT_W-1:0]      rem_cnt;

  // add goes to the matching slot, else claims the first free one at count zero
  assign add_go   = (op == OP_ADD) && (amount != '0) && (key != '0) && key_known &&
                    (flags.hit || flags.free_found);
  assign add_oh   = flags.hit ? hit_oh : free_oh;
  assign add_base = flags.hit ? hit_count : '0;
  assign add_room = COUNT_MAX - add_base;
  assign add_amt  = (amount <= add_room) ? amount : add_room;

  // remove is all or nothing
  assign rem_go  = (op == OP_REMOVE) && (amount != '0) && flags.hit && (hit_count >= amount);
  assign rem_cnt = hit_count - amount;

  always_comb begin
    slot_keys_nxt   = slot_keys;
    slot_counts_nxt = slot_counts;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (add_go && add_oh[i]) begin
        slot_keys_nxt[i]   = key;
        slot_counts_nxt[i] = add_base + add_amt;
      end
      if (rem_go && hit_oh[i]) begin
        slot_counts_nxt[i] = rem_cnt;
        if (rem_cnt == '0) begin
          slot_keys_nxt[i] = '0;
        end
      end
    end
  end

  assign added      = add_go ? add_amt : '0;
  assign removed_ok = rem_go;

endmodule

### rtl/keyed_saturating_count_table.sv
// keyed saturating count table: top level with input, table and result registers
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------------------
//   in_     | in  | tvalid / tready    | tdata: item_key, amount; tuser: opcode, key_known
//   out_    | out | tvalid / tready    | tdata: added, removed_ok, held_count, slots_used
//
// one request per cycle while out_tready stays high; a request passes through the input
// register, then one pass of lookup, update and re-lookup, into the result register
// the table registers and the result register are written in the same cycle, so each
// request sees every earlier one; no clearing pass, reset clears the table at once
// a stalled result holds the table still; the input register takes one more request,
// then in_tready drops until the result is transferred
module keyed_saturating_count_table
  import ksct_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // item_key[7:0], amount[15:8]
  input  logic [2:0]  in_tuser,   // opcode[1:0], key_known[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // added[7:0], removed_ok[8], held_count[16:9],
                                  // slots_used[20:17], zero[23:21]
);

`include "keyed_saturating_count_table_assert.svh"

  // input register
  logic             in_valid_r;
  opcode_t          in_op_r;
  logic [KEY_W-1:0] in_key_r;
  logic [CNT_W-1:0] in_amount_r;
  logic             in_known_r;

  // table
  logic [SLOT_COUNT-1:0][KEY_W-1:0] slot_keys_r;
  logic [SLOT_COUNT-1:0][CNT_W-1:0] slot_counts_r;
  logic [SLOT_COUNT-1:0][KEY_W-1:0] slot_keys_nxt;
  logic [SLOT_COUNT-1:0][CNT_W-1:0] slot_counts_nxt;

  // result register
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_added_r;
  logic              out_removed_ok_r;
  logic [CNT_W-1:0]  out_held_r;
  logic [USED_W-1:0] out_used_r;

  // lookup before the update
  logic [SLOT_COUNT-1:0] pre_hit_oh;
  logic [SLOT_COUNT-1:0] pre_free_oh;
  lookup_flags_t         pre_flags;
  logic [CNT_W-1:0]      pre_hit_count;

  // lookup after the update gives the reported count and occupancy
  logic [CNT_W-1:0]  post_held;
  logic [USED_W-1:0] post_used;

  logic [CNT_W-1:0] exec_added;
  logic             exec_removed_ok;

  logic advance;

  // occupancy consistency vectors, checked below
  logic [SLOT_COUNT-1:0] slot_key_nz;
  logic [SLOT_COUNT-1:0] slot_cnt_nz;

  // the input register moves into the result register when that one is free or drains
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // payload loads on every transfer
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r     <= opcode_t'(in_tuser[1:0]);
      in_known_r  <= in_tuser[2];
      in_key_r    <= in_tdata[7:0];
      in_amount_r <= in_tdata[15:8];
    end
  end

  ksct_lookup #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_lookup_pre (
    .slot_keys   (slot_keys_r),
    .slot_counts (slot_counts_r),
    .key         (in_key_r),
    .hit_oh      (pre_hit_oh),
    .free_oh     (pre_free_oh),
    .flags       (pre_flags),
    .hit_count   (pre_hit_count),
    .used_count  ()
  );

  ksct_exec #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_exec (
    .op              (in_op_r),
    .key             (in_key_r),
    .amount          (in_amount_r),
    .key_known       (in_known_r),
    .slot_keys       (slot_keys_r),
    .slot_counts     (slot_counts_r),
    .hit_oh          (pre_hit_oh),
    .free_oh         (pre_free_oh),
    .flags           (pre_flags),
    .hit_count       (pre_hit_count),
    .slot_keys_nxt   (slot_keys_nxt),
    .slot_counts_nxt (slot_counts_nxt),
    .added           (exec_added),
    .removed_ok      (exec_removed_ok)
  );

  ksct_lookup #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_lookup_post (
    .slot_keys   (slot_keys_nxt),
    .slot_counts (slot_counts_nxt),
    .key         (in_key_r),
    .hit_oh      (),
    .free_oh     (),
    .flags       (),
    .hit_count   (post_held),
    .used_count  (post_used)
  );

  // table state: cleared by reset, written once per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_keys_r   <= '0;
      slot_counts_r <= '0;
    end else if (advance) begin
      slot_keys_r   <= slot_keys_nxt;
      slot_counts_r <= slot_counts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_added_r      <= exec_added;
      out_removed_ok_r <= exec_removed_ok;
      out_held_r       <= post_held;
      out_used_r       <= post_used;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_used_r, out_held_r, out_removed_ok_r, out_added_r};

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_key_nz[i] = (slot_keys_r[i] != '0);
      slot_cnt_nz[i] = (slot_counts_r[i] != '0);
    end
  end

  // a slot holds a key exactly when it holds a nonzero count
  `KSCT_ASSERT_ALWAYS(a_key_count_paired, slot_key_nz == slot_cnt_nz)
  // one request cannot both add and remove
  `KSCT_ASSERT_SAME(a_add_xor_remove, out_valid_r, !(out_removed_ok_r && (out_added_r != '0)))
  // occupancy never exceeds the table size
  `KSCT_ASSERT_SAME(a_used_bound, out_valid_r, 32'(out_used_r) <= 32'(SLOT_COUNT))
  // a stalled result freezes the table
  `KSCT_ASSERT_NEXT(a_stall_holds_table, out_valid_r && !out_tready,
                    $stable(slot_counts_r) && $stable(slot_keys_r))

endmodule

### test/testbench.sv
// self-checking testbench for the keyed saturating count table
`timescale 1ns / 100ps

module testbench;
  import ksct_pkg::*;

  localparam int SLOTS = 8;
  // opcode three has no name in the package; the block treats it as a query
  localparam logic [1:0] OP_SPARE = 2'd3;
  // cycles without any transfer before the run is declared hung
  localparam int IDLE_LIMIT = 600;
  // receiver hold-off that backs the block up into its input
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RANDOM_REQUESTS = 950;

  // one request as it travels on the input channel
  typedef struct {
    logic [1:0] op;
    logic [7:0] key;
    logic [7:0] amount;
    logic       known;
  } request_t;

  // one response as it travels on the output channel
  typedef struct {
    logic [7:0] added;
    logic       removed_ok;
    logic [7:0] held_count;
    logic [3:0] slots_used;
    logic [2:0] pad;
  } response_t;

  // shadow copy of the table: predicts each response and checks it on arrival
  class table_mirror;
    logic [7:0] slot_keys[SLOTS];
    logic [7:0] slot_counts[SLOTS];
    response_t  expected_responses[$];
    int         mismatches;

    function new();
      foreach (slot_keys[i]) begin
        slot_keys[i]   = '0;
        slot_counts[i] = '0;
      end
      mismatches = 0;
    endfunction

    // first slot holding the key; key zero never matches
    function int locate_key(logic [7:0] key);
      if (key == 8'd0) return -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_keys[i] == key) return i;
      end
      return -1;
    endfunction

    // update the mirror with an accepted request and queue its response
    function void note_request(request_t r);
      response_t e;
      int        s;
      int        room;
      int        used;
      e.added      = '0;
      e.removed_ok = 1'b0;
      e.pad        = '0;
      if (r.op == OP_ADD) begin
        if (r.amount != 0 && r.key != 0 && r.known) begin
          s = locate_key(r.key);
          // no slot holds the key: claim the first free one
          for (int i = 0; i < SLOTS && s < 0; i++) begin
            if (slot_keys[i] == 0 || slot_counts[i] == 0) begin
              s              = i;
              slot_keys[i]   = r.key;
              slot_counts[i] = '0;
            end
          end
          if (s >= 0) begin
            room    = int'(COUNT_MAX) - int'(slot_counts[s]);
            e.added = (int'(r.amount) <= room) ? r.amount : 8'(room);
            slot_counts[s] = slot_counts[s] + e.added;
          end
        end
      end else if (r.op == OP_REMOVE) begin
        s = locate_key(r.key);
        // all or nothing; an emptied slot gives its key back
        if (r.amount != 0 && s >= 0 && slot_counts[s] >= r.amount) begin
          slot_counts[s] = slot_counts[s] - r.amount;
          if (slot_counts[s] == 0) slot_keys[s] = '0;
          e.removed_ok = 1'b1;
        end
      end
      s = locate_key(r.key);
      e.held_count = (s >= 0) ? slot_counts[s] : 8'd0;
      used = 0;
      foreach (slot_keys[i]) begin
        if (slot_keys[i] != 0 && slot_counts[i] != 0) used++;
      end
      e.slots_used = (used > int'(USED_MAX)) ? USED_MAX : 4'(used);
      expected_responses.push_back(e);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    // compare one transferred response with the oldest prediction
    task check_response(response_t got);
      response_t want;
      if (expected_responses.size() == 0) begin
        report("unexpected response, added", got.added, -1);
        return;
      end
      want = expected_responses.pop_front();
      if (got.added != want.added) report("added", got.added, want.added);
      if (got.removed_ok != want.removed_ok)
        report("removed_ok", got.removed_ok, want.removed_ok);
      if (got.held_count != want.held_count)
        report("held_count", got.held_count, want.held_count);
      if (got.slots_used != want.slots_used)
        report("slots_used", got.slots_used, want.slots_used);
      if (got.pad != want.pad) report("pad bits", got.pad, want.pad);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // item_key[7:0], amount[15:8]
  logic [2:0]  in_tuser;   // opcode[1:0], key_known[2]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // added[7:0], removed_ok[8], held_count[16:9],
                           // slots_used[20:17], zero[23:21]

  table_mirror mirror;
  int          responses_seen = 0;
  int          idle_cycles = 0;
  bit          sender_calm;
  bit          receiver_calm = 1'b0;

  keyed_saturating_count_table #(.SLOT_COUNT(SLOTS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // monitor: every transfer is sampled at the edge that completes it, so the
  // values seen here are the ones held during the cycle before the edge
  always @(posedge clk) begin
    request_t  r;
    response_t p;
    if (rst_n && in_tvalid && in_tready) begin
      r.key    = in_tdata[7:0];
      r.amount = in_tdata[15:8];
      r.op     = in_tuser[1:0];
      r.known  = in_tuser[2];
      mirror.note_request(r);
    end
    if (rst_n && out_tvalid && out_tready) begin
      p.added      = out_tdata[7:0];
      p.removed_ok = out_tdata[8];
      p.held_count = out_tdata[16:9];
      p.slots_used = out_tdata[20:17];
      p.pad        = out_tdata[23:21];
      mirror.check_response(p);
      responses_seen++;
    end
  end

  // watchdog: a run that stops moving is a failure
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // gap before a transfer; calm stretches run with no idling at all
  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // present one request and hold it until the block takes it; tvalid is only
  // dropped when a gap follows, never lowered and raised in the same step
  task automatic send_request(logic [1:0] op, logic [7:0] key, logic [7:0] amount,
                              logic known);
    int gap;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {amount, key};
    in_tuser  <= {known, op};
    do @(posedge clk); while (!in_tready);
  endtask

  // random request: mostly a small key pool so that hits, fills and frees
  // keep happening; the rest spreads over every key and amount
  task automatic send_random_request();
    logic [1:0] op;
    logic [7:0] key;
    logic [7:0] amount;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 42)      op = OP_ADD;
    else if (pick < 72) op = OP_REMOVE;
    else if (pick < 92) op = OP_QUERY;
    else                op = OP_SPARE;
    key = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 12))
                                     : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       amount = 8'($urandom_range(0, 4));
      1:       amount = 8'($urandom_range(1, 40));
      2:       amount = 8'($urandom_range(0, 255));
      default: amount = 8'($urandom_range(200, 255));
    endcase
    send_request(op, key, amount, $urandom_range(0, 9) != 0);
  endtask

  // receiver: random stalls per result, one long hold-off while the sender
  // keeps offering so the block fills and drops in_tready, and a calm stretch
  initial begin
    int  stall;
    bit  held_off;
    held_off = 1'b0;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && responses_seen >= 200) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        receiver_calm = (responses_seen >= 550 && responses_seen < 680);
        stall = draw_wait(receiver_calm);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    mirror         = new();
    sender_calm    = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: empty table, rejected adds, saturation, all-or-nothing
    // removes, a full table, slot reuse and the spare opcode
    send_request(OP_QUERY,  8'd0,   8'd0,   1'b0);
    send_request(OP_ADD,    8'd0,   8'd5,   1'b1);   // key zero rejected
    send_request(OP_ADD,    8'd5,   8'd0,   1'b1);   // zero amount rejected
    send_request(OP_ADD,    8'd5,   8'd7,   1'b0);   // unknown key rejected
    send_request(OP_ADD,    8'd5,   8'd200, 1'b1);
    send_request(OP_ADD,    8'd5,   8'd255, 1'b1);   // saturates, adds the rest
    send_request(OP_ADD,    8'd5,   8'd1,   1'b1);   // already at the top
    send_request(OP_REMOVE, 8'd5,   8'd0,   1'b1);   // zero amount fails
    send_request(OP_REMOVE, 8'd0,   8'd1,   1'b1);   // key zero never matches
    send_request(OP_REMOVE, 8'd5,   8'd255, 1'b0);   // key_known ignored, frees slot
    send_request(OP_REMOVE, 8'd5,   8'd1,   1'b1);   // no longer held
    for (int k = 1; k <= SLOTS; k++) begin
      send_request(OP_ADD, 8'(k), 8'd1, 1'b1);      // fill every slot
    end
    send_request(OP_ADD,    8'd255, 8'd9,   1'b1);   // table full, nothing added
    send_request(OP_REMOVE, 8'd3,   8'd2,   1'b1);   // more than held fails
    send_request(OP_REMOVE, 8'd3,   8'd1,   1'b1);   // frees a middle slot
    send_request(OP_ADD,    8'd255, 8'd255, 1'b1);   // reuses the freed slot
    send_request(OP_SPARE,  8'd1,   8'd128, 1'b1);   // spare opcode reads back
    send_request(OP_QUERY,  8'd255, 8'd0,   1'b1);

    // random part, with one stretch where the sender never idles
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      sender_calm = (n >= 480 && n < 600);
      send_random_request();
    end
    in_tvalid <= 1'b0;

    // drain, then a few edges for any stray response to show up
    while (mirror.expected_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### keyed_saturating_count_table.f
+incdir+rtl
rtl/ksct_pkg.sv
rtl/ksct_lookup.sv
rtl/ksct_exec.sv
rtl/keyed_saturating_count_table.sv
test/testbench.sv
